// File: hdl/bdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

   localparam int VALUE_W     = 32;
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 104;

   localparam logic [VALUE_W-1:0] ERR_VALUE = {VALUE_W{1'b1}};

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_BACK  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_READ       = 2'd3
   } req_op_type;

   typedef enum logic [1:0] {
      STS_OK      = 2'd0,
      STS_EMPTY   = 2'd1,
      STS_BAD_POS = 2'd2,
      STS_FULL    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ROTATE,
      S_RESPOND
   } state_type;

   typedef enum logic [2:0] {
      CHAIN_HOLD,
      CHAIN_PUSH_FRONT,
      CHAIN_PUSH_BACK,
      CHAIN_POP,
      CHAIN_ROTATE
   } chain_op_type;

   typedef struct packed {
      chain_op_type        op;
      logic [VALUE_W-1:0]  value;
   } chain_cmd_type;

endpackage

`default_nettype wire

// File: hdl/bdq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module bdq_cell (
   input  wire                                clock,
   input  wire                                reset,
   input  bdq_pkg::chain_cmd_type             cmd,
   input  wire                                left_occ,
   input  wire  [bdq_pkg::VALUE_W-1:0]        left_data,
   input  wire                                right_occ,
   input  wire  [bdq_pkg::VALUE_W-1:0]        right_data,
   input  wire  [bdq_pkg::VALUE_W-1:0]        front_data,
   output logic                               occ,
   output logic [bdq_pkg::VALUE_W-1:0]        data
);

   logic                         occ_ff;
   logic                         occ_in;
   logic [bdq_pkg::VALUE_W-1:0]  data_ff;
   logic [bdq_pkg::VALUE_W-1:0]  data_in;

   always_comb begin
      occ_in  = occ_ff;
      data_in = data_ff;
      case (cmd.op)
         bdq_pkg::CHAIN_PUSH_FRONT: begin
            occ_in  = left_occ;
            data_in = left_data;
         end
         bdq_pkg::CHAIN_PUSH_BACK: begin
            if (!occ_ff && left_occ) begin
               occ_in  = 1'b1;
               data_in = cmd.value;
            end
         end
         bdq_pkg::CHAIN_POP: begin
            occ_in  = right_occ;
            data_in = right_data;
         end
         bdq_pkg::CHAIN_ROTATE: begin
            // the front entry wraps round into the last occupied cell
            if (occ_ff && !right_occ) begin
               data_in = front_data;
            end else begin
               data_in = right_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign occ  = occ_ff;
   assign data = data_ff;

endmodule

`default_nettype wire

// File: hdl/bdq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bdq_ctrl #(
   parameter int DEPTH = 64
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [bdq_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  wire  [1:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [bdq_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic [1:0]                           rsp_tuser,
   input  wire  [bdq_pkg::VALUE_W-1:0]          front_data,
   input  wire  [bdq_pkg::VALUE_W-1:0]          second_data,
   output bdq_pkg::chain_cmd_type               cmd
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);

   bdq_pkg::state_type            state_ff;
   bdq_pkg::state_type            state_in;
   logic [CW-1:0]                 count_ff;
   logic [CW-1:0]                 count_in;
   logic [CW-1:0]                 count_m1;
   logic [AW-1:0]                 step_ff;
   logic [AW-1:0]                 pos_ff;
   logic [bdq_pkg::VALUE_W-1:0]   capture_ff;
   logic [bdq_pkg::VALUE_W-1:0]   last_ff;
   logic                          rsp_valid_ff;
   logic [bdq_pkg::VALUE_W-1:0]   rsp_read_ff;
   logic [bdq_pkg::VALUE_W-1:0]   rsp_first_ff;
   logic [bdq_pkg::VALUE_W-1:0]   rsp_last_ff;
   logic [6:0]                    rsp_count_ff;
   bdq_pkg::status_type           rsp_status_ff;

   bdq_pkg::req_op_type           req_op;
   logic [bdq_pkg::VALUE_W-1:0]   req_value;
   logic [31:0]                   req_position;
   logic                          slot_free;
   logic                          req_accept;
   logic                          is_empty;
   logic                          is_full;
   logic                          pos_ok;
   logic                          read_go;
   logic                          load_imm;
   logic                          load_read;
   logic                          rotate_done;

   bdq_pkg::status_type           imm_status;
   logic [bdq_pkg::VALUE_W-1:0]   imm_read;
   logic [bdq_pkg::VALUE_W-1:0]   new_first;
   logic [bdq_pkg::VALUE_W-1:0]   new_last;
   logic [bdq_pkg::VALUE_W-1:0]   imm_first;
   logic [bdq_pkg::VALUE_W-1:0]   imm_last;
   logic [31:0]                   count_ext;
   logic [31:0]                   new_count_ext;

   assign req_op       = bdq_pkg::req_op_type'(req_tuser);
   assign req_value    = req_tdata[31:0];
   assign req_position = req_tdata[63:32];
   assign slot_free    = !rsp_valid_ff || rsp_tready;
   assign req_tready   = (state_ff == bdq_pkg::S_IDLE) && slot_free;
   assign req_accept   = req_tvalid && req_tready;
   assign is_empty     = (count_ff == '0);
   assign is_full      = (count_ff == CW'(DEPTH));
   assign count_ext    = 32'(count_ff);
   assign pos_ok       = !req_position[31] && (count_ext > req_position);
   assign read_go      = req_accept && (req_op == bdq_pkg::OP_READ) && !is_empty && pos_ok;
   assign count_m1     = count_ff - CW'(1);
   assign rotate_done  = (step_ff == count_m1[AW-1:0]);
   assign load_imm     = req_accept && !read_go;
   assign load_read    = (state_ff == bdq_pkg::S_RESPOND) && slot_free;

   // result of a transaction that completes at once
   always_comb begin
      imm_status = bdq_pkg::STS_OK;
      imm_read   = '0;
      count_in   = count_ff;
      new_first  = front_data;
      new_last   = last_ff;
      case (req_op)
         bdq_pkg::OP_PUSH_FRONT: begin
            if (is_full) begin
               imm_status = bdq_pkg::STS_FULL;
            end else begin
               count_in  = count_ff + CW'(1);
               new_first = req_value;
               if (is_empty) begin
                  new_last = req_value;
               end
            end
         end
         bdq_pkg::OP_PUSH_BACK: begin
            if (is_full) begin
               imm_status = bdq_pkg::STS_FULL;
            end else begin
               count_in = count_ff + CW'(1);
               new_last = req_value;
               if (is_empty) begin
                  new_first = req_value;
               end
            end
         end
         bdq_pkg::OP_POP_FRONT: begin
            if (is_empty) begin
               imm_status = bdq_pkg::STS_EMPTY;
            end else begin
               count_in  = count_m1;
               new_first = second_data;
            end
         end
         bdq_pkg::OP_READ: begin
            if (is_empty) begin
               imm_read   = bdq_pkg::ERR_VALUE;
               imm_status = bdq_pkg::STS_EMPTY;
            end else if (!pos_ok) begin
               imm_read   = bdq_pkg::ERR_VALUE;
               imm_status = bdq_pkg::STS_BAD_POS;
            end
         end
         default: begin
         end
      endcase
      if (count_in == '0) begin
         imm_first = bdq_pkg::ERR_VALUE;
         imm_last  = bdq_pkg::ERR_VALUE;
      end else begin
         imm_first = new_first;
         imm_last  = new_last;
      end
   end

   assign new_count_ext = 32'(count_in);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bdq_pkg::S_IDLE: begin
            if (read_go) begin
               state_in = bdq_pkg::S_ROTATE;
            end
         end
         bdq_pkg::S_ROTATE: begin
            if (rotate_done) begin
               state_in = bdq_pkg::S_RESPOND;
            end
         end
         bdq_pkg::S_RESPOND: begin
            if (slot_free) begin
               state_in = bdq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bdq_pkg::S_IDLE;
         end
      endcase
   end

   // chain command
   always_comb begin
      cmd.op    = bdq_pkg::CHAIN_HOLD;
      cmd.value = req_value;
      case (state_ff)
         bdq_pkg::S_IDLE: begin
            if (req_accept) begin
               case (req_op)
                  bdq_pkg::OP_PUSH_FRONT: begin
                     if (!is_full) begin
                        cmd.op = bdq_pkg::CHAIN_PUSH_FRONT;
                     end
                  end
                  bdq_pkg::OP_PUSH_BACK: begin
                     if (!is_full) begin
                        cmd.op = bdq_pkg::CHAIN_PUSH_BACK;
                     end
                  end
                  bdq_pkg::OP_POP_FRONT: begin
                     if (!is_empty) begin
                        cmd.op = bdq_pkg::CHAIN_POP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         bdq_pkg::S_ROTATE: begin
            cmd.op = bdq_pkg::CHAIN_ROTATE;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdq_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_accept) begin
            count_ff <= count_in;
         end
         if (load_imm || load_read) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         last_ff <= new_last;
      end
      if (read_go) begin
         pos_ff  <= req_position[AW-1:0];
         step_ff <= '0;
      end else if (state_ff == bdq_pkg::S_ROTATE) begin
         step_ff <= step_ff + AW'(1);
         if (step_ff == pos_ff) begin
            capture_ff <= front_data;
         end
      end
      if (load_imm) begin
         rsp_read_ff   <= imm_read;
         rsp_first_ff  <= imm_first;
         rsp_last_ff   <= imm_last;
         rsp_count_ff  <= new_count_ext[6:0];
         rsp_status_ff <= imm_status;
      end else if (load_read) begin
         rsp_read_ff   <= capture_ff;
         rsp_first_ff  <= front_data;
         rsp_last_ff   <= last_ff;
         rsp_count_ff  <= count_ext[6:0];
         rsp_status_ff <= bdq_pkg::STS_OK;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_last_ff, rsp_first_ff, rsp_read_ff};
   assign rsp_tuser  = rsp_status_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond depth");

   a_push_back_count: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_op == bdq_pkg::OP_PUSH_BACK) && !is_full
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("push back did not grow the count");

   a_rotate_flow: assert property (@(posedge clock) disable iff (reset)
      state_ff == bdq_pkg::S_ROTATE
      |=> state_ff == bdq_pkg::S_ROTATE || state_ff == bdq_pkg::S_RESPOND)
      else $error("rotation left early");

   a_rotate_count_stable: assert property (@(posedge clock) disable iff (reset)
      state_ff == bdq_pkg::S_ROTATE |=> $stable(count_ff))
      else $error("count changed during rotation");

   a_read_go_nonempty: assert property (@(posedge clock) disable iff (reset)
      read_go |-> !is_empty && !rsp_valid_ff || read_go && rsp_tready)
      else $error("read started without a free slot");
`endif

endmodule

`default_nettype wire

// File: hdl/bounded_deque_with_index_read.sv
`timescale 1ns / 1ps
`default_nettype none

// Bounded double-ended queue of signed 32-bit values held in a row of DEPTH cells, cell 0
// being the front. Push front, push back, pop front and every failed operation take one
// transaction per cycle unless the response stalls. A good read at a position rotates the
// occupied cells one place per cycle through cell 0, captures the entry as it passes, and
// after count steps leaves the row in its original order. Each transaction gives one
// response carrying the read value, the front and back entries, the count and a status.

module bounded_deque_with_index_read #(
   parameter int DEPTH = 64
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [bdq_pkg::REQ_TDATA_W-1:0]     req_tdata,  // value, position
   input  wire  [1:0]                          req_tuser,  // op
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [bdq_pkg::RSP_TDATA_W-1:0]     rsp_tdata,  // read_value, first_value,
                                                           // last_value, entry_count
   output logic [1:0]                          rsp_tuser   // status
);

   bdq_pkg::chain_cmd_type         cmd;
   logic [DEPTH-1:0]               occ;
   logic [bdq_pkg::VALUE_W-1:0]    data [DEPTH];

   bdq_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .front_data  (data[0]),
      .second_data (data[1]),
      .cmd         (cmd)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                         left_occ;
      logic [bdq_pkg::VALUE_W-1:0]  left_data;
      logic                         right_occ;
      logic [bdq_pkg::VALUE_W-1:0]  right_data;

      if (i == 0) begin : g_head
         assign left_occ  = 1'b1;
         assign left_data = cmd.value;
      end else begin : g_body
         assign left_occ  = occ[i-1];
         assign left_data = data[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_occ  = 1'b0;
         assign right_data = data[0];
      end else begin : g_inner
         assign right_occ  = occ[i+1];
         assign right_data = data[i+1];
      end

      bdq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_occ   (left_occ),
         .left_data  (left_data),
         .right_occ  (right_occ),
         .right_data (right_data),
         .front_data (data[0]),
         .occ        (occ[i]),
         .data       (data[i])
      );
   end

endmodule

`default_nettype wire

// File: test/deque_result_checker.sv
`timescale 1ns / 1ps

module deque_result_checker #(
   parameter int DEPTH = 64
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   input  wire                                 req_tready,
   input  wire  [bdq_pkg::REQ_TDATA_W-1:0]     req_tdata,  // value, position
   input  wire  [1:0]                          req_tuser,  // op
   input  wire                                 rsp_tvalid,
   input  wire                                 rsp_tready,
   input  wire  [bdq_pkg::RSP_TDATA_W-1:0]     rsp_tdata,  // read_value, first_value,
                                                           // last_value, entry_count
   input  wire  [1:0]                          rsp_tuser,  // status
   output int                                  fail_count,
   output int                                  outstanding,
   output int                                  results_checked,
   output int                                  items_accepted
);

   import bdq_pkg::*;

   typedef struct packed {
      logic [VALUE_W-1:0] read_value;
      logic [VALUE_W-1:0] first_value;
      logic [VALUE_W-1:0] last_value;
      logic [6:0]         entry_count;
      status_type         status;
   } deque_result_type;

   logic [VALUE_W-1:0] held_entries [DEPTH];
   int                 head_slot;
   int                 held_count;
   deque_result_type   pending_results [$];

   // applies one operation to the local copy of the deque and returns its response
   function automatic deque_result_type apply_deque_op(input req_op_type op,
                                                        input logic [31:0] value,
                                                        input logic [31:0] pos);
      deque_result_type res;
      res = '0;
      res.status = STS_OK;
      case (op)
         OP_PUSH_FRONT: begin
            if (held_count >= DEPTH) begin
               res.status = STS_FULL;
            end else begin
               head_slot = (head_slot + DEPTH - 1) % DEPTH;
               held_entries[head_slot] = value;
               held_count++;
            end
         end
         OP_PUSH_BACK: begin
            if (held_count >= DEPTH) begin
               res.status = STS_FULL;
            end else begin
               held_entries[(head_slot + held_count) % DEPTH] = value;
               held_count++;
            end
         end
         OP_POP_FRONT: begin
            if (held_count == 0) begin
               res.status = STS_EMPTY;
            end else begin
               head_slot = (head_slot + 1) % DEPTH;
               held_count--;
            end
         end
         default: begin
            if (held_count == 0) begin
               res.read_value = ERR_VALUE;
               res.status = STS_EMPTY;
            end else if (pos[31] || pos >= 32'(held_count)) begin
               res.read_value = ERR_VALUE;
               res.status = STS_BAD_POS;
            end else begin
               res.read_value = held_entries[(head_slot + int'(pos)) % DEPTH];
            end
         end
      endcase
      if (held_count == 0) begin
         res.first_value = ERR_VALUE;
         res.last_value = ERR_VALUE;
      end else begin
         res.first_value = held_entries[head_slot];
         res.last_value = held_entries[(head_slot + held_count - 1) % DEPTH];
      end
      res.entry_count = 7'(held_count);
      return res;
   endfunction

   task automatic flag_mismatch(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      deque_result_type want;
      if (reset) begin
         head_slot = 0;
         held_count = 0;
         pending_results.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            pending_results.push_back(apply_deque_op(req_op_type'(req_tuser),
                                                     req_tdata[31:0], req_tdata[63:32]));
            items_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               fail_count++;
               $display("%0t: response with nothing expected, expected none, got %h / %h",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               want = pending_results.pop_front();
               flag_mismatch("read_value", want.read_value, rsp_tdata[31:0]);
               flag_mismatch("first_value", want.first_value, rsp_tdata[63:32]);
               flag_mismatch("last_value", want.last_value, rsp_tdata[95:64]);
               flag_mismatch("entry_count", 32'(want.entry_count), 32'(rsp_tdata[102:96]));
               flag_mismatch("status", 32'(want.status), 32'(rsp_tuser));
               results_checked++;
            end
         end
      end
      outstanding = pending_results.size();
   end

endmodule

// File: test/tb_bounded_deque_with_index_read.sv
`timescale 1ns / 1ps

module tb_bounded_deque_with_index_read;

   import bdq_pkg::*;

   localparam int DEPTH        = 64;
   localparam int RANDOM_ITEMS = 1500;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int TAIL_CYCLES  = 2 * DEPTH + 16;

   localparam int FILL_UP = 0;
   localparam int DRAIN   = 1;
   localparam int MIXED   = 2;

   localparam int READY_ALWAYS   = 0;
   localparam int READY_COIN     = 1;
   localparam int READY_MOSTLY   = 2;
   localparam int READY_PERIODIC = 3;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [1:0]             req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [1:0]             rsp_tuser;

   int fail_count;
   int outstanding;
   int results_checked;
   int items_accepted;

   int burst_left;
   bit no_gaps;
   int shadow_count;
   int peak_fill;
   int full_drops;
   int empty_hits;
   int bad_reads;
   int hold_requests;
   int cycle_count;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   bounded_deque_with_index_read #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   deque_result_checker #(
      .DEPTH(DEPTH)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .fail_count(fail_count),
      .outstanding(outstanding),
      .results_checked(results_checked),
      .items_accepted(items_accepted)
   );

   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // offers one transaction and returns on the falling edge after it is taken
   task automatic send_item(input req_op_type op, input logic [31:0] value,
                            input logic [31:0] pos);
      int gap;
      if (burst_left == 0) begin
         gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (shadow_count == DEPTH) full_drops++;
            else shadow_count++;
         end
         OP_POP_FRONT: begin
            if (shadow_count == 0) empty_hits++;
            else shadow_count--;
         end
         default: begin
            if (shadow_count == 0) empty_hits++;
            else if (pos[31] || pos >= 32'(shadow_count)) bad_reads++;
         end
      endcase
      if (shadow_count > peak_fill) peak_fill = shadow_count;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {pos, value};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   initial begin
      int n;
      int roll;
      int regime;
      req_op_type op;
      logic [31:0] value;
      logic [31:0] pos;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty store, extreme values, front and back ordering, bad positions
      send_item(OP_READ, 32'h0, 32'h0);
      send_item(OP_POP_FRONT, 32'h0, 32'h0);
      send_item(OP_READ, 32'h0, 32'hFFFF_FFFF);
      send_item(OP_PUSH_BACK, 32'h7FFF_FFFF, 32'h0);
      send_item(OP_PUSH_FRONT, 32'h8000_0000, 32'h0);
      send_item(OP_PUSH_BACK, 32'hFFFF_FFFF, 32'h0);
      send_item(OP_PUSH_FRONT, 32'h0000_0000, 32'h0);
      for (n = 0; n < 5; n++) send_item(OP_READ, $urandom, n);
      send_item(OP_READ, 32'h0, 32'hFFFF_FFFF);
      send_item(OP_READ, 32'h0, 32'h8000_0000);
      send_item(OP_READ, 32'h0, 32'h7FFF_FFFF);
      send_item(OP_POP_FRONT, 32'h0, 32'h0);
      send_item(OP_READ, 32'h0, 32'h0);
      for (n = 0; n < 4; n++) send_item(OP_POP_FRONT, $urandom, $urandom);

      regime = MIXED;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) begin
            regime = $urandom_range(FILL_UP, MIXED);
            no_gaps = ($urandom_range(0, 3) == 0);
         end
         if (n == 300 || n == 900) hold_requests++;
         roll = $urandom_range(0, 99);
         case (regime)
            FILL_UP: op = (roll < 35) ? OP_PUSH_FRONT : (roll < 65) ? OP_PUSH_BACK :
                          (roll < 75) ? OP_POP_FRONT : OP_READ;
            DRAIN:   op = (roll < 10) ? OP_PUSH_FRONT : (roll < 20) ? OP_PUSH_BACK :
                          (roll < 65) ? OP_POP_FRONT : OP_READ;
            default: op = (roll < 22) ? OP_PUSH_FRONT : (roll < 44) ? OP_PUSH_BACK :
                          (roll < 66) ? OP_POP_FRONT : OP_READ;
         endcase
         value = random_word();
         if (op != OP_READ) begin
            pos = random_word();
         end else if (shadow_count > 0 && $urandom_range(0, 3) != 0) begin
            pos = $urandom_range(0, shadow_count - 1);
         end else begin
            case ($urandom_range(0, 3))
               0: pos = {1'b1, 31'($urandom)};
               1: pos = shadow_count;
               2: pos = shadow_count + $urandom_range(1, 2 * DEPTH);
               default: pos = random_word();
            endcase
         end
         send_item(op, value, pos);
      end
      req_tvalid <= 1'b0;

      while (outstanding != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      $display("%0d transactions sent, %0d responses checked, peak fill %0d of %0d",
               items_accepted, results_checked, peak_fill, DEPTH);
      $display("%0d pushes on a full store, %0d ops on an empty store, %0d bad positions",
               full_drops, empty_hits, bad_reads);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // response back-pressure with its own pattern and occasional long hold-offs
   initial begin
      int mode;
      int mode_left;
      int beat;
      int holds_served;
      rsp_tready = 1'b0;
      mode = READY_ALWAYS;
      mode_left = 0;
      beat = 0;
      holds_served = 0;
      forever begin
         @(negedge clock);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            rsp_tready <= 1'b0;
            repeat ($urandom_range(150, 300)) @(negedge clock);
         end
         if (mode_left == 0) begin
            mode = $urandom_range(READY_ALWAYS, READY_PERIODIC);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         beat++;
         case (mode)
            READY_ALWAYS:   rsp_tready <= 1'b1;
            READY_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
            READY_MOSTLY:   rsp_tready <= ($urandom_range(0, 7) != 0);
            default:        rsp_tready <= (beat % 3 == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

endmodule
